[sv/scqg_pkg.sv]
// Shared constants and types of the scissor clip quad generator.
package scqg_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int UV_BITS_DEF     = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CLIP_SIZE_BITS  = 15;
	localparam int EDGE_BITS       = 10;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int QUADS_PER_REQ   = 4;

	localparam logic [CLIP_SIZE_BITS-1:0] CLIP_SIZE_RESET = 15'h7fff;
	localparam logic [EDGE_BITS-1:0]      EDGE_RESET      = 10'd16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CLIP_ENABLE    = 3'd0,
		REG_CLIP_LEFT      = 3'd1,
		REG_CLIP_TOP       = 3'd2,
		REG_CLIP_WIDTH     = 3'd3,
		REG_CLIP_HEIGHT    = 3'd4,
		REG_EDGE_THICKNESS = 3'd5
	} cfg_reg_e;

	typedef enum logic {
		OP_QUAD    = 1'b0,
		OP_OUTLINE = 1'b1
	} op_e;

	typedef struct packed {
		logic                      clip_enable;
		logic [CLIP_SIZE_BITS-1:0] clip_width;
		logic [CLIP_SIZE_BITS-1:0] clip_height;
		logic [EDGE_BITS-1:0]      edge_thickness;
	} cfg_ctrl_t;

endpackage

[sv/scqg_fifo.sv]
// Small register queue between the request front end and the UV back end.
module scqg_fifo import scqg_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/scqg_front.sv]
// Request front end: outline expansion, emptiness and scissor tests, quad issue.
module scqg_front import scqg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int UV_BITS    = UV_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((4*COORD_BITS+4*UV_BITS+7)/8)*8-1:0] s_tdata,
	input  logic                                   s_tuser,
	input  cfg_ctrl_t                              cfg,
	input  logic [COORD_BITS-1:0]                  clip_left,
	input  logic [COORD_BITS-1:0]                  clip_top,
	output logic                                   q_valid,
	input  logic                                   q_ready,
	output logic [10*COORD_BITS+4*UV_BITS:0]       q_data
);

	localparam int C  = COORD_BITS;
	localparam int U  = UV_BITS;
	localparam int WW = ((C > CLIP_SIZE_BITS) ? C : CLIP_SIZE_BITS) + 2;
	localparam logic signed [WW-1:0] CMAX = WW'((64'sd1 <<< (C - 1)) - 64'sd1);
	localparam logic signed [WW-1:0] CMIN = -CMAX - WW'(1);

	function automatic logic signed [WW-1:0] sat(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] r;
		if (v < CMIN) begin
			r = CMIN;
		end else if (v > CMAX) begin
			r = CMAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic                 busy_s1;
	logic                 op_s1;
	logic signed [C-1:0]  l_s1, t_s1, r_s1, b_s1;
	logic [U-1:0]         u0_s1, v0_s1, u1_s1, v1_s1;
	logic [QUADS_PER_REQ-1:0] sent_q;

	logic signed [WW-1:0] el, et, er, eb, th, sl, st, sr, sb;
	logic signed [WW-1:0] tin, bin, lin, rin;
	logic signed [WW-1:0] qx0 [QUADS_PER_REQ];
	logic signed [WW-1:0] qy0 [QUADS_PER_REQ];
	logic signed [WW-1:0] qx1 [QUADS_PER_REQ];
	logic signed [WW-1:0] qy1 [QUADS_PER_REQ];
	logic signed [WW-1:0] cx0 [QUADS_PER_REQ];
	logic signed [WW-1:0] cy0 [QUADS_PER_REQ];
	logic signed [WW-1:0] cx1 [QUADS_PER_REQ];
	logic signed [WW-1:0] cy1 [QUADS_PER_REQ];
	logic [QUADS_PER_REQ-1:0] surv, live, rem, pick;
	logic [1:0]           sel;
	logic                 is_last, push_ok, done_now, accept, outline;
	logic [U-1:0]         uu0, vv0, uu1, vv1;

	assign el  = WW'(l_s1);
	assign et  = WW'(t_s1);
	assign er  = WW'(r_s1);
	assign eb  = WW'(b_s1);
	assign th  = $signed({{(WW-EDGE_BITS){1'b0}}, cfg.edge_thickness});
	assign sl  = WW'($signed(clip_left));
	assign st  = WW'($signed(clip_top));
	assign sr  = sl + $signed({{(WW-CLIP_SIZE_BITS){1'b0}}, cfg.clip_width});
	assign sb  = st + $signed({{(WW-CLIP_SIZE_BITS){1'b0}}, cfg.clip_height});
	assign tin = sat(et + th);
	assign bin = sat(eb - th);
	assign lin = sat(el + th);
	assign rin = sat(er - th);
	assign outline = (op_s1 == OP_OUTLINE);

	always_comb begin
		qx0[0] = el;  qy0[0] = et;  qx1[0] = er;  qy1[0] = outline ? tin : eb;
		qx0[1] = el;  qy0[1] = bin; qx1[1] = er;  qy1[1] = eb;
		qx0[2] = el;  qy0[2] = tin; qx1[2] = lin; qy1[2] = bin;
		qx0[3] = rin; qy0[3] = tin; qx1[3] = er;  qy1[3] = bin;
		for (int i = 0; i < QUADS_PER_REQ; i++) begin
			cx0[i] = (cfg.clip_enable && sl > qx0[i]) ? sl : qx0[i];
			cy0[i] = (cfg.clip_enable && st > qy0[i]) ? st : qy0[i];
			cx1[i] = (cfg.clip_enable && sr < qx1[i]) ? sr : qx1[i];
			cy1[i] = (cfg.clip_enable && sb < qy1[i]) ? sb : qy1[i];
			surv[i] = (qx1[i] > qx0[i]) && (qy1[i] > qy0[i]) &&
			          (cx1[i] > cx0[i]) && (cy1[i] > cy0[i]);
		end
	end

	// An outline whose outer rectangle is empty gives nothing, even where an
	// edge quad on its own would not be empty.
	assign live = outline ? (((er > el) && (eb > et)) ? 4'b1111 : 4'b0000) : 4'b0001;
	assign rem  = busy_s1 ? (surv & live & ~sent_q) : '0;

	always_comb begin
		if (rem[0]) begin
			sel = 2'd0;
		end else if (rem[1]) begin
			sel = 2'd1;
		end else if (rem[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
	end

	assign pick     = 4'b0001 << sel;
	assign is_last  = ((rem & ~pick) == '0);
	assign q_valid  = (rem != '0);
	assign push_ok  = q_valid && q_ready;
	assign done_now = busy_s1 && ((rem == '0) || (push_ok && is_last));
	assign s_tready = !busy_s1 || done_now;
	assign accept   = s_tvalid && s_tready;

	assign uu0 = outline ? '0 : u0_s1;
	assign vv0 = outline ? '0 : v0_s1;
	assign uu1 = outline ? '0 : u1_s1;
	assign vv1 = outline ? '0 : v1_s1;

	always_comb begin
		logic signed [WW-1:0] wx, wy, dx0, dy0, dx1, dy1;
		wx  = qx1[sel] - qx0[sel];
		wy  = qy1[sel] - qy0[sel];
		dx0 = cx0[sel] - qx0[sel];
		dy0 = cy0[sel] - qy0[sel];
		dx1 = cx1[sel] - qx0[sel];
		dy1 = cy1[sel] - qy0[sel];
		q_data = {is_last, vv1, uu1, vv0, uu0,
		          wy[C-1:0], wx[C-1:0], dy1[C-1:0], dx1[C-1:0], dy0[C-1:0], dx0[C-1:0],
		          cy1[sel][C-1:0], cx1[sel][C-1:0], cy0[sel][C-1:0], cx0[sel][C-1:0]};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= s_tuser;
			l_s1  <= s_tdata[0*C +: C];
			t_s1  <= s_tdata[1*C +: C];
			r_s1  <= s_tdata[2*C +: C];
			b_s1  <= s_tdata[3*C +: C];
			u0_s1 <= s_tdata[4*C +: U];
			v0_s1 <= s_tdata[4*C+U +: U];
			u1_s1 <= s_tdata[4*C+2*U +: U];
			v1_s1 <= s_tdata[4*C+3*U +: U];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			sent_q  <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
				sent_q  <= '0;
			end else if (done_now) begin
				busy_s1 <= 1'b0;
			end else if (push_ok) begin
				sent_q <= sent_q | pick;
			end
		end
	end

endmodule

[sv/scqg_back.sv]
// Quad back end: texture coordinate remap with an iterative divider and output register.
module scqg_back import scqg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int UV_BITS    = UV_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         q_valid,
	output logic                                         q_ready,
	input  logic [10*COORD_BITS+4*UV_BITS:0]             q_data,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	output logic [((4*COORD_BITS+4*UV_BITS+7)/8)*8-1:0]  m_tdata,
	output logic                                         m_tlast
);

	localparam int C       = COORD_BITS;
	localparam int U       = UV_BITS;
	localparam int EW      = 10*C + 4*U + 1;
	localparam int OW      = ((4*C + 4*U + 7) / 8) * 8;
	localparam int STEPS   = 4;
	localparam int DIV_CYC = (U + STEPS - 1) / STEPS;
	localparam int QW      = DIV_CYC * STEPS;
	localparam int CNTW    = $clog2(DIV_CYC);
	localparam int LANES   = 4;

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

	state_t          state_q;
	logic [EW-1:0]   e_q;
	logic [C-1:0]    rem_q [LANES];
	logic [QW-1:0]   quo_q [LANES];
	logic [CNTW-1:0] cnt_q;
	logic            out_valid_q;
	logic [OW-1:0]   out_data_q;
	logic            out_last_q;

	logic [EW-1:0]   src;
	logic [U-1:0]    la [LANES];
	logic [U-1:0]    lb [LANES];
	logic [U-1:0]    lm [LANES];
	logic [C-1:0]    ld [LANES];
	logic [C-1:0]    lw [LANES];
	logic [U-1:0]    triv_res [LANES];
	logic [U-1:0]    div_res [LANES];
	logic [C-1:0]    rem_nx [LANES];
	logic [QW-1:0]   quo_nx [LANES];
	logic [C+QW-1:0] prod [LANES];
	logic [LANES-1:0] triv;
	logic            all_triv, out_free, pop, load;

	assign src      = (state_q == S_IDLE) ? q_data : e_q;
	assign out_free = !out_valid_q || m_tready;
	assign q_ready  = (state_q == S_IDLE) && (all_triv ? out_free : 1'b1);
	assign pop      = q_valid && q_ready;
	assign load     = ((state_q == S_IDLE) && pop && all_triv) ||
	                  ((state_q == S_FIN) && out_free);

	// Lanes in output order: u at clipped left, v at clipped top, u at
	// clipped right, v at clipped bottom.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			la[i] = src[10*C + (i % 2)*U +: U];
			lb[i] = src[10*C + (2 + i % 2)*U +: U];
			ld[i] = src[(4 + i)*C +: C];
			lw[i] = src[(8 + i % 2)*C +: C];
			lm[i] = (lb[i] >= la[i]) ? lb[i] - la[i] : la[i] - lb[i];
			triv[i] = (lm[i] == '0) || (ld[i] == '0) || (ld[i] == lw[i]);
			triv_res[i] = (ld[i] == lw[i]) ? lb[i] : la[i];
			prod[i] = (C+QW)'(ld[i]) * (C+QW)'(lm[i]);
		end
	end
	assign all_triv = &triv;

	// Restoring division, several quotient bits per cycle. The remainder
	// always stays below the divisor, so it needs only the divisor's width.
	always_comb begin
		logic [C:0]    r;
		logic [C-1:0]  rm;
		logic [QW-1:0] qo;
		for (int i = 0; i < LANES; i++) begin
			rm = rem_q[i];
			qo = quo_q[i];
			for (int k = 0; k < STEPS; k++) begin
				r  = {rm, qo[QW-1]};
				qo = {qo[QW-2:0], 1'b0};
				if (r >= {1'b0, lw[i]}) begin
					r     = r - {1'b0, lw[i]};
					qo[0] = 1'b1;
				end
				rm = r[C-1:0];
			end
			rem_nx[i] = rm;
			quo_nx[i] = qo;
		end
	end

	always_comb begin
		logic [U:0] qv;
		logic [U:0] sum;
		for (int i = 0; i < LANES; i++) begin
			qv = (U+1)'(quo_q[i][U-1:0]) + (U+1)'({rem_q[i], 1'b0} >= {1'b0, lw[i]});
			sum = (lb[i] >= la[i]) ? (U+1)'(la[i]) + qv : (U+1)'(la[i]) - qv;
			div_res[i] = sum[U-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (all_triv) begin
							out_last_q  <= src[EW-1];
							out_data_q  <= OW'({triv_res[3], triv_res[2], triv_res[1],
							                   triv_res[0], src[4*C-1:0]});
						end else begin
							e_q     <= q_data;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					for (int i = 0; i < LANES; i++) begin
						rem_q[i] <= prod[i][C+QW-1:QW];
						quo_q[i] <= prod[i][QW-1:0];
					end
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					for (int i = 0; i < LANES; i++) begin
						rem_q[i] <= rem_nx[i];
						quo_q[i] <= quo_nx[i];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(DIV_CYC - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_last_q  <= src[EW-1];
						out_data_q  <= OW'({div_res[3], div_res[2], div_res[1],
						                   div_res[0], src[4*C-1:0]});
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

[sv/scissor_clip_quad_generator.sv]
// Scissor clip quad generator top level: configuration registers, front end, queue, back end.
// A request is taken by the front end, which issues its quads in turn as the queue
// takes them and takes the next request as it issues the last quad. A quad whose
// texture coordinates need no division (solid or outline quads, unclipped quads, or
// edges that fall exactly on the quad's own edges) goes from the queue straight into
// the output register. A clipped textured quad passes through a multiply step, the
// steps of the four-bit-per-cycle divider of each lane and a final step, and the back
// end takes no other quad meanwhile. A four-entry queue lets the front end run ahead
// while the back end divides, and the output register holds a finished quad while the
// next one is worked on. Configuration is written through cfg_we, cfg_index and cfg_data
// and takes effect at once; write it only while the block is idle.
module scissor_clip_quad_generator import scqg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int UV_BITS    = UV_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// left, top, right, bottom, tex_u_start, tex_v_start, tex_u_end, tex_v_end
	input  logic [((4*COORD_BITS+4*UV_BITS+7)/8)*8-1:0] s_tdata,
	// op
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// out_left, out_top, out_right, out_bottom, out_u_start, out_v_start, out_u_end,
	// out_v_end
	output logic [((4*COORD_BITS+4*UV_BITS+7)/8)*8-1:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [((COORD_BITS > CLIP_SIZE_BITS) ? COORD_BITS : CLIP_SIZE_BITS)-1:0] cfg_data
);

	localparam int EW = 10*COORD_BITS + 4*UV_BITS + 1;

	cfg_ctrl_t               cfg_q;
	logic [COORD_BITS-1:0]   clip_left_q, clip_top_q;
	logic                    fq_wr_valid, fq_wr_ready, fq_rd_valid, fq_rd_ready;
	logic [EW-1:0]           fq_wr_data, fq_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_enable    <= 1'b0;
			cfg_q.clip_width     <= CLIP_SIZE_RESET;
			cfg_q.clip_height    <= CLIP_SIZE_RESET;
			cfg_q.edge_thickness <= EDGE_RESET;
			clip_left_q          <= '0;
			clip_top_q           <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_CLIP_ENABLE:    cfg_q.clip_enable    <= cfg_data[0];
				REG_CLIP_LEFT:      clip_left_q          <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_TOP:       clip_top_q           <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_WIDTH:     cfg_q.clip_width     <= cfg_data[CLIP_SIZE_BITS-1:0];
				REG_CLIP_HEIGHT:    cfg_q.clip_height    <= cfg_data[CLIP_SIZE_BITS-1:0];
				REG_EDGE_THICKNESS: cfg_q.edge_thickness <= cfg_data[EDGE_BITS-1:0];
				default: ;
			endcase
		end
	end

	scqg_front #(
		.COORD_BITS(COORD_BITS),
		.UV_BITS   (UV_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg       (cfg_q),
		.clip_left (clip_left_q),
		.clip_top  (clip_top_q),
		.q_valid   (fq_wr_valid),
		.q_ready   (fq_wr_ready),
		.q_data    (fq_wr_data)
	);

	scqg_fifo #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_wr_valid),
		.wr_ready (fq_wr_ready),
		.wr_data  (fq_wr_data),
		.rd_valid (fq_rd_valid),
		.rd_ready (fq_rd_ready),
		.rd_data  (fq_rd_data)
	);

	scqg_back #(
		.COORD_BITS(COORD_BITS),
		.UV_BITS   (UV_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (fq_rd_valid),
		.q_ready  (fq_rd_ready),
		.q_data   (fq_rd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
